// ----- sv/uvst_pkg.sv -----
// ---------------------------------------------------------------------------
// uvst_pkg
// Shared codes, widths and controller/datapath handshake structs for the
// unique value set table.
// ---------------------------------------------------------------------------
package uvst_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // load the item and restart the scan
    logic scan;    // walk the stored entries
    logic finish;  // commit the operation and load the result register
  } uvst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } uvst_sts_t;

endpackage

// ----- sv/uvst_ram.sv -----
// ---------------------------------------------------------------------------
// uvst_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module uvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/uvst_dp.sv -----
// ---------------------------------------------------------------------------
// uvst_dp
// Datapath: item registers, entry scan with compare, erase shift, count
// update and the output register.
// ---------------------------------------------------------------------------
module uvst_dp
  import uvst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  uvst_cmd_t              cmd,
  output uvst_sts_t              sts,
  input  logic [1:0]             in_action,
  input  logic [VALUE_W-1:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  action_t           act;
  logic [VALUE_W-1:0] val;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [CW-1:0]     rd_idx;
  logic              cmp_valid;
  logic [IW-1:0]     cmp_idx;
  logic              hit;

  logic              issue;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [VALUE_W-1:0] wdata;
  logic [VALUE_W-1:0] rdata;
  logic              match;
  status_t           status;

  assign issue = cmd.scan && (rd_idx < cnt);
  assign match = cmp_valid && (rdata == val);

  assign sts.scan_done = (cnt == '0) ||
                         (cmp_valid && (CW'(cmp_idx) == cnt - 1'b1));
  assign sts.out_free  = !out_valid || out_ready;

  // commit logic for the finishing cycle
  always_comb begin
    cnt_next = cnt;
    status   = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (!hit) begin
          if (cnt >= CAP) begin
            status = ST_FULL;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ACT_FIND: begin
        cnt_next = cnt;
      end
      ACT_ERASE: begin
        if (hit) begin
          cnt_next = cnt - 1'b1;
        end else begin
          status = ST_ABSENT;
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  // entries after the hit move down one place during an erase scan
  always_comb begin
    we    = 1'b0;
    waddr = cmp_idx - 1'b1;
    wdata = rdata;
    if (cmd.finish) begin
      we    = (act == ACT_INSERT) && !hit && (cnt < CAP);
      waddr = cnt[IW-1:0];
      wdata = val;
    end else if (cmd.scan && cmp_valid && !match && hit && (act == ACT_ERASE)) begin
      we = 1'b1;
    end
  end

  uvst_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(rd_idx[IW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.start) begin
        act       <= action_t'(in_action);
        val       <= in_value;
        rd_idx    <= '0;
        cmp_valid <= 1'b0;
        hit       <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
        cmp_idx   <= rd_idx[IW-1:0];
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
      end else if (cmd.finish) begin
        cnt       <= cnt_next;
        out_data  <= {7'd0, (cnt_next == '0), COUNT_W'(cnt_next), status, hit};
      end
    end
  end

endmodule

// ----- sv/uvst_ctrl.sv -----
// ---------------------------------------------------------------------------
// uvst_ctrl
// Controller: sequences accept, entry scan and commit for one item at a time.
// ---------------------------------------------------------------------------
module uvst_ctrl
  import uvst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  uvst_sts_t sts,
  output uvst_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.start  = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.finish = (state == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // wait here while the previous result is still held
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/unique_value_set_table.sv -----
// ---------------------------------------------------------------------------
// unique_value_set_table
// Set of distinct 32-bit values kept packed in a RAM with a stored count;
// insert, find, erase and clear each give one result item.
// ---------------------------------------------------------------------------
//  channel  direction  tdata                      tuser
//  s_axis   in         [31:0] value               [1:0] action
//  m_axis   out        [0] found, [2:1] status,   -
//                      [7:3] count, [8] is_empty
//
//  an item passes through accept, a scan that reads the entry RAM one
//  address a cycle over the stored entries, and commit; the single RAM
//  read port sets the pace of the scan
//  erase shifts later entries down during the same scan
//  the result sits in an output register, so a stalled m_axis only holds the
//  commit cycle; reset empties the set at once, with no clearing pass
// ---------------------------------------------------------------------------
module unique_value_set_table
  import uvst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
  input  logic [1:0]             s_axis_tuser,   // [1:0] action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found, status, count, is_empty
);

  uvst_cmd_t cmd;
  uvst_sts_t sts;

  uvst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  uvst_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_action(s_axis_tuser),
    .in_value (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule
